// File: rtl/core/shb_pkg.sv
// Shared types, codes and fixed widths of the spatial hash bucket table.
package shb_pkg;

	localparam int COORD_W = 16;
	localparam int ENT_W   = 16;

	localparam logic [1:0] MODE_MOVE   = 2'd0;
	localparam logic [1:0] MODE_DELETE = 2'd1;
	localparam logic [1:0] MODE_QUERY  = 2'd2;

	localparam logic [1:0] STAT_DONE = 2'd0;
	localparam logic [1:0] STAT_SAME = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;
	localparam logic [1:0] STAT_SLOT = 2'd3;

	// Order in which the four coordinates pass through the remainder unit.
	localparam logic [1:0] CRD_PX = 2'd0;
	localparam logic [1:0] CRD_PY = 2'd1;
	localparam logic [1:0] CRD_NX = 2'd2;
	localparam logic [1:0] CRD_NY = 2'd3;

	typedef struct packed {
		logic        [1:0]         mode;
		logic        [ENT_W-1:0]   entity_id;
		logic signed [COORD_W-1:0] prev_x;
		logic signed [COORD_W-1:0] prev_y;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [ENT_W-1:0] slot_entity;
		logic             slot_used;
		logic             last;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_RD_OLD,
		ST_WR_OLD,
		ST_RD_NEW,
		ST_WR_NEW,
		ST_QUERY,
		ST_RESP
	} shb_state_t;

endpackage

// File: rtl/core/spatial_hash_bucket_table.sv
// Top level of the spatial hash bucket table: sequencer, slot edit logic and result register.
//
//   Channel | Direction | Handshake        | Payload
//   req     | in        | req_valid/stall  | shb_pkg::req_t (mode, id, old and new position)
//   rsp     | out       | rsp_valid/stall  | shb_pkg::rsp_t (status, slot, used flag, last)
//
// Every coordinate goes through one shared remainder unit (a reciprocal multiply, then a
// subtract and one correction step), and the four coordinates are hashed one after
// another. A move or delete then reads and rewrites the old and the new bucket row; a
// query reads the new bucket row and reports each of its slots as a result.
// A move to an unchanged position and an undefined mode answer without touching the store.
// After reset a clearing pass writes every bucket row empty, during which req_stall
// stays high. A stalled result holds in the output register; the next request is taken
// while the last result of the previous one still waits there.
module spatial_hash_bucket_table #(
	parameter int GRID_SIZE        = 16,
	parameter int SLOTS_PER_BUCKET = 8,
	parameter int ID_BITS          = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  shb_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output shb_pkg::rsp_t rsp
);

	localparam int HW      = $clog2(GRID_SIZE);
	localparam int NUM_BKT = GRID_SIZE * GRID_SIZE;
	localparam int BKT_W   = $clog2(NUM_BKT);
	localparam int ROW_W   = SLOTS_PER_BUCKET * ID_BITS;
	localparam int QW      = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;

	localparam logic [BKT_W-1:0]   G_B       = BKT_W'(GRID_SIZE);
	localparam logic [BKT_W-1:0]   BKT_LAST  = BKT_W'(NUM_BKT - 1);
	localparam logic [QW-1:0]      SLOT_LAST = QW'(SLOTS_PER_BUCKET - 1);
	localparam logic [ID_BITS-1:0] EMPTY_ID  = '1;

	shb_pkg::shb_state_t state_q;
	shb_pkg::shb_state_t state_d;

	shb_pkg::req_t  req_q;
	shb_pkg::rsp_t  pend_q;
	shb_pkg::rsp_t  rsp_q;
	shb_pkg::rsp_t  rsp_d;
	logic           rsp_valid_q;
	logic           rsp_load;

	logic [1:0]       sel_q;
	logic [HW-1:0]    h_q [4];
	logic [BKT_W-1:0] clr_q;
	logic [QW-1:0]    qcnt_q;

	logic                  accept;
	logic                  out_free;
	logic                  imm;
	logic                  same_pos;
	logic                  mode_known;
	logic                  q_last;
	logic [ID_BITS-1:0]    id;
	logic [BKT_W-1:0]      old_bkt;
	logic [BKT_W-1:0]      new_bkt;

	logic                              ru_start;
	logic signed [shb_pkg::COORD_W-1:0] ru_coord;
	logic                              ru_busy;
	logic                              ru_done;
	logic [HW-1:0]                     ru_rem;

	logic             wr_en;
	logic [BKT_W-1:0] wr_addr;
	logic [ROW_W-1:0] wr_data;
	logic             rd_en;
	logic [BKT_W-1:0] rd_addr;
	logic [ROW_W-1:0] rd_data;

	logic [ID_BITS-1:0]          slot_a [SLOTS_PER_BUCKET];
	logic [SLOTS_PER_BUCKET-1:0] match_v;
	logic [SLOTS_PER_BUCKET-1:0] empty_v;
	logic [SLOTS_PER_BUCKET-1:0] match_first;
	logic [SLOTS_PER_BUCKET-1:0] empty_first;
	logic [ROW_W-1:0]            clr_row;
	logic [ROW_W-1:0]            add_row;
	logic                        bkt_full;

	// The block takes a request only between items; during the clearing pass
	// and while an item is in flight the request side is stalled.
	assign req_stall = (state_q != shb_pkg::ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// A move to the same position and an undefined mode skip the hash and answer
	// from the result state, without touching the store.
	assign same_pos   = (req.prev_x == req.pos_x) && (req.prev_y == req.pos_y);
	assign mode_known = (req.mode == shb_pkg::MODE_MOVE) || (req.mode == shb_pkg::MODE_DELETE)
	                    || (req.mode == shb_pkg::MODE_QUERY);
	assign imm        = ((req.mode == shb_pkg::MODE_MOVE) && same_pos) || !mode_known;

	// Ids wider than the marker field are cut; narrower ones are zero extended.
	assign id = ID_BITS'(req_q.entity_id);

	// Bucket index is the row-major position of (hash x, hash y) in the grid.
	assign old_bkt = BKT_W'(h_q[shb_pkg::CRD_PX]) * G_B + BKT_W'(h_q[shb_pkg::CRD_PY]);
	assign new_bkt = BKT_W'(h_q[shb_pkg::CRD_NX]) * G_B + BKT_W'(h_q[shb_pkg::CRD_NY]);

	assign q_last = (qcnt_q == SLOT_LAST);

	// Slot edit logic works on the registered read row. The lowest set bit of
	// each vector picks the first matching or first empty slot.
	always_comb begin
		for (int i = 0; i < SLOTS_PER_BUCKET; i++) begin
			slot_a[i]  = rd_data[i*ID_BITS +: ID_BITS];
			match_v[i] = (slot_a[i] == id);
			empty_v[i] = (slot_a[i] == EMPTY_ID);
		end
		match_first = match_v & (~match_v + 1'b1);
		empty_first = empty_v & (~empty_v + 1'b1);
		bkt_full    = (empty_v == '0);
		for (int i = 0; i < SLOTS_PER_BUCKET; i++) begin
			clr_row[i*ID_BITS +: ID_BITS] = match_first[i] ? EMPTY_ID : slot_a[i];
			add_row[i*ID_BITS +: ID_BITS] = empty_first[i] ? id : slot_a[i];
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			shb_pkg::ST_CLEAR: begin
				if (clr_q == BKT_LAST) begin
					state_d = shb_pkg::ST_IDLE;
				end
			end
			shb_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = imm ? shb_pkg::ST_RESP : shb_pkg::ST_HASH;
				end
			end
			shb_pkg::ST_HASH: begin
				if (ru_done && (sel_q == shb_pkg::CRD_NY)) begin
					state_d = (req_q.mode == shb_pkg::MODE_QUERY) ? shb_pkg::ST_RD_NEW
					                                              : shb_pkg::ST_RD_OLD;
				end
			end
			shb_pkg::ST_RD_OLD: state_d = shb_pkg::ST_WR_OLD;
			shb_pkg::ST_WR_OLD: state_d = shb_pkg::ST_RD_NEW;
			shb_pkg::ST_RD_NEW: begin
				state_d = (req_q.mode == shb_pkg::MODE_QUERY) ? shb_pkg::ST_QUERY
				                                              : shb_pkg::ST_WR_NEW;
			end
			shb_pkg::ST_WR_NEW: state_d = shb_pkg::ST_RESP;
			shb_pkg::ST_QUERY: begin
				if (out_free && q_last) begin
					state_d = shb_pkg::ST_IDLE;
				end
			end
			shb_pkg::ST_RESP: begin
				if (out_free) begin
					state_d = shb_pkg::ST_IDLE;
				end
			end
			default: state_d = shb_pkg::ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer: remainder unit, memory ports and the
	// result register.
	always_comb begin
		ru_start = 1'b0;
		ru_coord = req.prev_x;
		wr_en    = 1'b0;
		wr_addr  = old_bkt;
		wr_data  = clr_row;
		rd_en    = 1'b0;
		rd_addr  = old_bkt;
		rsp_load = 1'b0;
		rsp_d    = pend_q;
		unique case (state_q)
			shb_pkg::ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '1;
			end
			shb_pkg::ST_IDLE: begin
				ru_start = accept && !imm;
			end
			shb_pkg::ST_HASH: begin
				ru_start = ru_done && (sel_q != shb_pkg::CRD_NY);
				unique case (2'(sel_q + 2'd1))
					shb_pkg::CRD_PX: ru_coord = req_q.prev_x;
					shb_pkg::CRD_PY: ru_coord = req_q.prev_y;
					shb_pkg::CRD_NX: ru_coord = req_q.pos_x;
					shb_pkg::CRD_NY: ru_coord = req_q.pos_y;
					default:         ru_coord = req_q.prev_x;
				endcase
			end
			shb_pkg::ST_RD_OLD: begin
				rd_en = 1'b1;
			end
			shb_pkg::ST_WR_OLD: begin
				wr_en = 1'b1;
			end
			shb_pkg::ST_RD_NEW: begin
				rd_en   = 1'b1;
				rd_addr = new_bkt;
			end
			shb_pkg::ST_WR_NEW: begin
				wr_en   = 1'b1;
				wr_addr = new_bkt;
				wr_data = (req_q.mode == shb_pkg::MODE_MOVE) ? add_row : clr_row;
			end
			shb_pkg::ST_QUERY: begin
				rsp_load          = out_free;
				rsp_d.status      = shb_pkg::STAT_SLOT;
				rsp_d.slot_entity = shb_pkg::ENT_W'(slot_a[qcnt_q]);
				rsp_d.slot_used   = (slot_a[qcnt_q] != EMPTY_ID);
				rsp_d.last        = q_last;
			end
			shb_pkg::ST_RESP: begin
				rsp_load = out_free;
			end
			default: begin
				rsp_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= shb_pkg::ST_CLEAR;
			clr_q       <= '0;
			sel_q       <= '0;
			qcnt_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == shb_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (accept) begin
				sel_q <= shb_pkg::CRD_PX;
			end else if ((state_q == shb_pkg::ST_HASH) && ru_done) begin
				sel_q <= sel_q + 2'd1;
			end
			if (state_q == shb_pkg::ST_RD_NEW) begin
				qcnt_q <= '0;
			end else if ((state_q == shb_pkg::ST_QUERY) && out_free) begin
				qcnt_q <= qcnt_q + 1'b1;
			end
			if (out_free) begin
				rsp_valid_q <= rsp_load;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q              <= req;
			pend_q.status      <= ((req.mode == shb_pkg::MODE_MOVE) && same_pos)
			                      ? shb_pkg::STAT_SAME : shb_pkg::STAT_DONE;
			pend_q.slot_entity <= '0;
			pend_q.slot_used   <= 1'b0;
			pend_q.last        <= 1'b1;
		end else if (state_q == shb_pkg::ST_WR_NEW) begin
			pend_q.status <= ((req_q.mode == shb_pkg::MODE_MOVE) && bkt_full)
			                 ? shb_pkg::STAT_FULL : shb_pkg::STAT_DONE;
		end
		if ((state_q == shb_pkg::ST_HASH) && ru_done) begin
			h_q[sel_q] <= ru_rem;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	shb_rem_unit #(
		.GRID_SIZE(GRID_SIZE)
	) u_rem (
		.clk   (clk),
		.arst_n(arst_n),
		.start (ru_start),
		.coord (ru_coord),
		.busy  (ru_busy),
		.done  (ru_done),
		.rem   (ru_rem)
	);

	shb_bucket_mem #(
		.DEPTH(NUM_BKT),
		.WIDTH(ROW_W)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// The sequencer never restarts the remainder unit in the middle of a coordinate.
	a_rem_start: assert property (@(posedge clk) disable iff (!arst_n)
		ru_start |-> !ru_busy)
		else $error("remainder unit started while busy");

	// Only query slots come in runs; every other result closes its request.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.status != shb_pkg::STAT_SLOT)) |-> rsp.last)
		else $error("non-query result without last");

	// A request taken is always followed by a busy cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != shb_pkg::ST_IDLE))
		else $error("sequencer idle right after a request");

endmodule

// File: rtl/core/shb_rem_unit.sv
// Shared unit that maps a signed coordinate to abs(c rem GRID_SIZE).
module shb_rem_unit #(
	parameter int GRID_SIZE = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [shb_pkg::COORD_W-1:0]  coord,
	output logic                                busy,
	output logic                                done,
	output logic [$clog2(GRID_SIZE)-1:0]        rem
);

	localparam int HW = $clog2(GRID_SIZE);
	localparam int CW = shb_pkg::COORD_W;
	localparam int PW = 2 * CW;
	// Rounded-down reciprocal; the quotient taken from it is low by at most one.
	localparam logic [CW-1:0] RECIP = CW'((1 << CW) / GRID_SIZE);
	localparam logic [CW-1:0] G_C   = CW'(GRID_SIZE);

	logic          busy_q;
	logic          done_q;
	logic          fix_q;
	logic [CW-1:0] mag_q;
	logic [PW-1:0] prod_q;
	logic [HW-1:0] rem_q;
	logic [CW-1:0] mag_start;
	logic [CW-1:0] quo;
	logic [CW-1:0] rem_est;
	logic [CW-1:0] rem_fix;

	// Truncating remainder keeps the dividend's sign, so its magnitude is
	// the remainder of the magnitude.
	assign mag_start = coord[CW-1] ? (~coord + 1'b1) : coord;

	// After the multiply, the remainder from the estimated quotient lies below twice the
	// grid size, so one compare and subtract corrects it.
	assign quo     = prod_q[PW-1:CW];
	assign rem_est = mag_q - quo * G_C;
	assign rem_fix = (rem_est >= G_C) ? (rem_est - G_C) : rem_est;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			fix_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				fix_q  <= 1'b0;
			end else if (busy_q) begin
				fix_q <= 1'b1;
				if (fix_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag_start;
		end
		if (busy_q && !fix_q) begin
			prod_q <= PW'(mag_q) * PW'(RECIP);
		end
		if (busy_q && fix_q) begin
			rem_q <= rem_fix[HW-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rem  = rem_q;

endmodule

// File: rtl/core/shb_bucket_mem.sv
// Bucket memory: one row per bucket, one write and one registered read a cycle.
module shb_bucket_mem #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: dv/tb_top.sv
// Self-checking testbench of the spatial hash bucket table: directed table, random traffic, predictor.
module tb_top;
	import shb_pkg::*;

	// Geometry of the block under test; the instance keeps its default parameters.
	localparam int GRID  = 16;
	localparam int SLOTS = 8;
	localparam int CELLS = GRID * GRID * SLOTS;
	localparam logic [ENT_W-1:0] EMPTY_ID = '1;

	// Mode 3 has no meaning; the block still answers it with a single done result.
	localparam logic [1:0] MODE_UNDEF = 2'd3;

	localparam int DIR_ROWS       = 23;
	localparam int RANDOM_ITEMS   = 350;
	localparam int POOL_SIZE      = 24;
	localparam int HOLD_OFF_AFTER = 40;
	localparam int HOLD_OFF_LEN   = 400;
	localparam int DRAIN_CYCLES   = 60;
	localparam int WATCHDOG_LIMIT = 3000;

	// One row of the directed table. When fixed is set, the single result of the row is
	// typed in by hand and replaces what the predictor says for it.
	typedef struct {
		req_t       rq;
		bit         fixed;
		logic [1:0] status;
	} dir_row_t;

	logic  clk;
	logic  arst_n    = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_stall;
	req_t  req       = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	// Predictor state: every slot of every bucket, and the queue of results still owed.
	logic [ENT_W-1:0] grid_slots [CELLS];
	rsp_t             due_results [$];
	int               mismatch_count = 0;

	// Last known position of each entity in the random pool, so that most moves and
	// deletes name the bucket the entity really sits in.
	logic signed [COORD_W-1:0] pool_x [POOL_SIZE];
	logic signed [COORD_W-1:0] pool_y [POOL_SIZE];

	// The sender raises this once enough random requests are out; the receiver then holds
	// off for a long stretch so that the block fills up and stalls its request side.
	bit hold_off_go   = 1'b0;
	bit hold_off_done = 1'b0;

	dir_row_t dir_table [DIR_ROWS];

	spatial_hash_bucket_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------------------

	// A coordinate picks its bucket row by the magnitude of its truncating remainder, so
	// -15 and 15 land in the same row.
	function automatic int coord_bucket(logic signed [COORD_W-1:0] c);
		int r;
		r = int'(c) % GRID;
		if (r < 0) begin
			r = -r;
		end
		return r;
	endfunction

	function automatic int bucket_base(logic signed [COORD_W-1:0] cx,
	                                   logic signed [COORD_W-1:0] cy);
		return (coord_bucket(cx) * GRID + coord_bucket(cy)) * SLOTS;
	endfunction

	// Only the first matching slot is cleared; a duplicate copy of the id stays behind.
	function automatic void clear_first(int base, logic [ENT_W-1:0] id);
		bit hit;
		hit = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			if (!hit && grid_slots[base + i] == id) begin
				grid_slots[base + i] = EMPTY_ID;
				hit = 1'b1;
			end
		end
	endfunction

	// Returns 0 when the bucket has no empty slot. Writing the empty marker into an empty
	// slot leaves the store as it was but still counts as a success.
	function automatic bit place_first(int base, logic [ENT_W-1:0] id);
		bit hit;
		hit = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			if (!hit && grid_slots[base + i] == EMPTY_ID) begin
				grid_slots[base + i] = id;
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	function automatic rsp_t make_rsp(logic [1:0] st, logic [ENT_W-1:0] ent, logic used,
	                                  logic lst);
		rsp_t r;
		r.status      = st;
		r.slot_entity = ent;
		r.slot_used   = used;
		r.last        = lst;
		return r;
	endfunction

	// Applies one accepted request to the predicted store and queues its results.
	function automatic void apply_bucket_op(req_t rq);
		int  ob;
		int  nb;
		bit  placed;
		logic [ENT_W-1:0] v;
		ob = bucket_base(rq.prev_x, rq.prev_y);
		nb = bucket_base(rq.pos_x, rq.pos_y);
		case (rq.mode)
			MODE_MOVE: begin
				if (rq.prev_x == rq.pos_x && rq.prev_y == rq.pos_y) begin
					due_results.push_back(make_rsp(STAT_SAME, '0, 1'b0, 1'b1));
				end else begin
					clear_first(ob, rq.entity_id);
					placed = place_first(nb, rq.entity_id);
					due_results.push_back(make_rsp(placed ? STAT_DONE : STAT_FULL,
					                               '0, 1'b0, 1'b1));
				end
			end
			MODE_DELETE: begin
				clear_first(ob, rq.entity_id);
				clear_first(nb, rq.entity_id);
				due_results.push_back(make_rsp(STAT_DONE, '0, 1'b0, 1'b1));
			end
			MODE_QUERY: begin
				for (int k = 0; k < SLOTS; k++) begin
					v = grid_slots[nb + k];
					due_results.push_back(make_rsp(STAT_SLOT, v, v != EMPTY_ID,
					                               k == SLOTS - 1));
				end
			end
			default: begin
				due_results.push_back(make_rsp(STAT_DONE, '0, 1'b0, 1'b1));
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------------------

	function automatic req_t make_req(logic [1:0] m, int id, int px, int py, int nx, int ny);
		req_t r;
		r.mode      = m;
		r.entity_id = 16'(id);
		r.prev_x    = 16'(px);
		r.prev_y    = 16'(py);
		r.pos_x     = 16'(nx);
		r.pos_y     = 16'(ny);
		return r;
	endfunction

	function automatic dir_row_t row(logic [1:0] m, int id, int px, int py, int nx, int ny,
	                                 bit fixed, logic [1:0] st);
		dir_row_t d;
		d.rq     = make_req(m, id, px, py, nx, ny);
		d.fixed  = fixed;
		d.status = st;
		return d;
	endfunction

	// Idle lengths: half of them zero, most of the rest short, a few long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// Most coordinates fall into a 3x3 patch of buckets, reached through values all over the
	// signed range, so buckets fill up; the rest are fully random.
	function automatic logic signed [COORD_W-1:0] rand_coord();
		int v;
		if ($urandom_range(0, 9) < 8) begin
			v = $urandom_range(0, 2) + GRID * $urandom_range(0, 2047);
			if ($urandom_range(0, 1) == 1) begin
				v = -v;
			end
			return 16'(v);
		end
		return 16'($urandom);
	endfunction

	// The pool spans the id range; its last member is the largest legal id.
	function automatic logic [ENT_W-1:0] pool_id(int e);
		if (e == POOL_SIZE - 1) begin
			return EMPTY_ID - 1'b1;
		end
		return 16'(e * 2731);
	endfunction

	// Mostly well-formed traffic: pool entities moved from where they are and deleted from
	// where they sit, queries over the hot patch; the rest is random ids, stale positions
	// and the undefined mode.
	task automatic gen_random(output req_t rq);
		int r;
		int e;
		bit tracked;
		r       = $urandom_range(0, 99);
		e       = $urandom_range(0, POOL_SIZE - 1);
		tracked = $urandom_range(0, 9) < 8;
		rq      = make_req(MODE_MOVE, 0, 0, 0, 0, 0);
		if (tracked) begin
			rq.entity_id = pool_id(e);
			rq.prev_x    = pool_x[e];
			rq.prev_y    = pool_y[e];
		end else begin
			rq.entity_id = 16'($urandom);
			rq.prev_x    = rand_coord();
			rq.prev_y    = rand_coord();
		end
		rq.pos_x = rand_coord();
		rq.pos_y = rand_coord();
		if (r < 55) begin
			rq.mode = MODE_MOVE;
			if ($urandom_range(0, 19) == 0) begin
				rq.pos_x = rq.prev_x;
				rq.pos_y = rq.prev_y;
			end
			if (tracked) begin
				pool_x[e] = rq.pos_x;
				pool_y[e] = rq.pos_y;
			end
		end else if (r < 75) begin
			rq.mode = MODE_DELETE;
		end else if (r < 97) begin
			rq.mode = MODE_QUERY;
		end else begin
			rq.mode = MODE_UNDEF;
		end
	endtask

	// Offers one request after a random gap and waits until the block takes it. The
	// prediction is made at the edge of acceptance, so it sees the store in request order.
	task automatic send_request(req_t rq, bit fixed, logic [1:0] st);
		int n;
		n = idle_len();
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		req       <= rq;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		apply_bucket_op(rq);
		if (fixed) begin
			due_results[due_results.size() - 1] = make_rsp(st, '0, 1'b0, 1'b1);
		end
	endtask

	// ------------------------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------------------------

	task automatic check_result(rsp_t got);
		rsp_t want;
		if (due_results.size() == 0) begin
			$display("%0t: unexpected result status=%0d slot_entity=%h slot_used=%0d last=%0d",
			         $time, got.status, got.slot_entity, got.slot_used, got.last);
			mismatch_count++;
		end else begin
			want = due_results.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d",
				         $time, want.status, got.status);
				mismatch_count++;
			end
			if (got.slot_entity !== want.slot_entity) begin
				$display("%0t: slot_entity expected %h actual %h",
				         $time, want.slot_entity, got.slot_entity);
				mismatch_count++;
			end
			if (got.slot_used !== want.slot_used) begin
				$display("%0t: slot_used expected %0d actual %0d",
				         $time, want.slot_used, got.slot_used);
				mismatch_count++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last expected %0d actual %0d",
				         $time, want.last, got.last);
				mismatch_count++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			check_result(rsp);
		end
	end

	// ------------------------------------------------------------------------------------
	// Receiver: random stalls, quiet stretches, and one long hold-off.
	// ------------------------------------------------------------------------------------
	initial begin : receiver
		int n;
		forever begin
			rsp_stall <= 1'b0;
			if ($urandom_range(0, 29) == 0) begin
				repeat (80) @(posedge clk);
			end else begin
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			if (hold_off_go && !hold_off_done) begin
				rsp_stall     <= 1'b1;
				hold_off_done  = 1'b1;
				repeat (HOLD_OFF_LEN) @(posedge clk);
			end else begin
				n = idle_len();
				if (n > 0) begin
					rsp_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
			end
		end
	end

	// ------------------------------------------------------------------------------------
	// Watchdog: ends the run when nothing moves on either channel for too long. The clearing
	// pass after reset and the long hold-off both fit well inside the limit.
	// ------------------------------------------------------------------------------------
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("%0t: watchdog expired with %0d results outstanding",
		         $time, due_results.size());
		$display("Mismatches found");
		$finish;
	end

	// ------------------------------------------------------------------------------------
	// Main sequence: reset, directed table, random traffic, drain, verdict.
	// ------------------------------------------------------------------------------------
	initial begin : stimulus
		req_t rq;
		for (int i = 0; i < CELLS; i++) begin
			grid_slots[i] = EMPTY_ID;
		end
		for (int e = 0; e < POOL_SIZE; e++) begin
			pool_x[e] = '0;
			pool_y[e] = '0;
		end

		// Bucket (15,15) is reached through 32767, -32767, -15, 15, 31, 47 and -31: all
		// have a remainder of magnitude 15. Bucket (0,0) is reached through -32768, 16, -16.
		dir_table = '{
			// Query of an empty bucket right after reset.
			row(MODE_QUERY,  0,      0,     0,      0,      0,      1'b0, STAT_DONE),
			// Move to the position the entity already has.
			row(MODE_MOVE,   1,      0,     0,      0,      0,      1'b1, STAT_SAME),
			row(MODE_MOVE,   1,      100,   100,    -32768, -32768, 1'b1, STAT_DONE),
			row(MODE_QUERY,  0,      0,     0,      16,     32,     1'b0, STAT_DONE),
			// Fill bucket (15,15), the id extremes among the entries.
			row(MODE_MOVE,   0,      1,     2,      32767,  32767,  1'b1, STAT_DONE),
			row(MODE_MOVE,   65534,  1,     2,      -32767, -32767, 1'b1, STAT_DONE),
			row(MODE_MOVE,   12,     1,     2,      -15,    15,     1'b1, STAT_DONE),
			row(MODE_MOVE,   13,     1,     2,      31,     -15,    1'b1, STAT_DONE),
			row(MODE_MOVE,   14,     1,     2,      47,     47,     1'b1, STAT_DONE),
			row(MODE_MOVE,   15,     1,     2,      15,     -31,    1'b1, STAT_DONE),
			row(MODE_MOVE,   16,     1,     2,      -47,    31,     1'b1, STAT_DONE),
			row(MODE_MOVE,   17,     1,     2,      15,     15,     1'b1, STAT_DONE),
			// Bucket full: the id is dropped, and so is the empty marker.
			row(MODE_MOVE,   18,     1,     2,      15,     15,     1'b1, STAT_FULL),
			row(MODE_MOVE,   65535,  1,     2,      -15,    -15,    1'b1, STAT_FULL),
			// The empty marker into a bucket with room changes nothing.
			row(MODE_MOVE,   65535,  1,     2,      3,      3,      1'b1, STAT_DONE),
			row(MODE_QUERY,  0,      0,     0,      -15,    32767,  1'b0, STAT_DONE),
			// The same id lands a second time in bucket (0,0).
			row(MODE_MOVE,   1,      5,     5,      0,      16,     1'b1, STAT_DONE),
			// Delete with old and new in the same bucket clears both copies.
			row(MODE_DELETE, 1,      0,     0,      -16,    16,     1'b1, STAT_DONE),
			row(MODE_QUERY,  0,      0,     0,      0,      0,      1'b0, STAT_DONE),
			row(MODE_DELETE, 65534,  15,    15,     3,      3,      1'b1, STAT_DONE),
			// Move between two positions of one bucket: the id takes the first free slot.
			row(MODE_MOVE,   12,     15,    15,     -31,    47,     1'b1, STAT_DONE),
			// Undefined mode with every field at all ones.
			row(MODE_UNDEF,  65535,  -1,    -1,     -1,     -1,     1'b1, STAT_DONE),
			row(MODE_QUERY,  0,      0,     0,      15,     15,     1'b0, STAT_DONE)
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[i]) begin
			send_request(dir_table[i].rq, dir_table[i].fixed, dir_table[i].status);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == HOLD_OFF_AFTER) begin
				hold_off_go = 1'b1;
			end
			gen_random(rq);
			send_request(rq, 1'b0, STAT_DONE);
		end
		req_valid <= 1'b0;

		// Drain: the watchdog covers a result that never comes.
		while (due_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/core/shb_pkg.sv
rtl/core/shb_rem_unit.sv
rtl/core/shb_bucket_mem.sv
rtl/core/spatial_hash_bucket_table.sv
dv/tb_top.sv
